// ----- hw/rtl/hsr_pkg.sv -----
// Shared types, constants and register codes of the humidity sensor reader.
`default_nettype none

package hsr_pkg;

    localparam int HSR_FRAME_BITS  = 40;
    localparam int HSR_QUEUE_DEPTH = 2;
    localparam int HSR_REG_IDX_W   = 2;
    localparam int HSR_CFG_DATA_W  = 16;

    localparam logic [15:0] HSR_START_LOW_RST = 16'd18000;
    localparam logic [7:0]  HSR_RELEASE_RST   = 8'd40;
    localparam logic [15:0] HSR_TIMEOUT_RST   = 16'd10000;
    localparam logic [7:0]  HSR_THRESHOLD_RST = 8'd40;

    typedef enum logic [HSR_REG_IDX_W-1:0] {
        REG_START_LOW = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_TIMEOUT   = 2'd2,
        REG_THRESHOLD = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TIMEOUT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  one_threshold_ticks;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic start_request;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] humidity;
        logic [7:0] temperature;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsr_fifo.sv -----
// Small register queue used on both sides of the reader engine.
`default_nettype none

module hsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsr_engine.sv -----
// Reader engine: start pulse, acknowledge waits, bit timing and frame check.
`default_nettype none

module hsr_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hsr_pkg::cfg_t   cfg,
    input  wire hsr_pkg::item_t  item,
    input  wire logic            item_valid,
    output logic                 item_take,
    input  wire logic            res_full,
    output logic                 res_push,
    output hsr_pkg::result_t     res
);

    import hsr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_LOW = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_ACK_LOW   = 3'd3,
        PH_ACK_HIGH  = 3'd4,
        PH_BIT_LOW   = 3'd5,
        PH_BIT_HIGH  = 3'd6
    } phase_t;

    localparam logic [5:0] FRAME_BITS_6 = 6'(HSR_FRAME_BITS);

    phase_t      phase_reg, phase_next, work_ph;
    logic [15:0] phase_ticks_reg, phase_ticks_next, work_pt, pt_inc;
    logic [15:0] pulse_ticks_reg, pulse_ticks_next, work_pu;
    logic [5:0]  bit_count_reg, bit_count_next, work_bc, bc_inc;
    logic [HSR_FRAME_BITS-1:0] frame_reg, frame_next, work_fs;
    logic [7:0]  humidity_reg, humidity_next;
    logic [7:0]  temperature_reg, temperature_next;
    logic [1:0]  status_reg, status_next;
    logic        is_idle;
    logic        start;
    logic        drive;
    logic        done;
    logic        timed_out;
    logic        bit_val;
    logic [7:0]  sum8;

    assign item_take = item_valid && !res_full;
    assign res_push  = item_take;

    always_comb
    begin
        is_idle = (phase_reg == PH_IDLE) || (phase_reg > PH_BIT_HIGH);
        start   = is_idle && item.start_request;
        work_ph = is_idle ? (item.start_request ? PH_START_LOW : PH_IDLE) : phase_reg;
        work_pt = start ? '0 : phase_ticks_reg;
        work_pu = start ? '0 : pulse_ticks_reg;
        work_bc = start ? '0 : bit_count_reg;
        work_fs = start ? '0 : frame_reg;
        pt_inc  = work_pt + 16'd1;
        bc_inc  = work_bc + 6'd1;
        bit_val = (work_pu > {8'd0, cfg.one_threshold_ticks});
        sum8    = '0;

        phase_next       = work_ph;
        phase_ticks_next = work_pt;
        pulse_ticks_next = work_pu;
        bit_count_next   = work_bc;
        frame_next       = work_fs;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        status_next      = status_reg;
        drive            = 1'b0;
        done             = 1'b0;
        timed_out        = 1'b0;

        unique case (work_ph)
            PH_START_LOW:
            begin
                drive = 1'b1;
                if (pt_inc >= cfg.start_low_ticks)
                begin
                    phase_next       = PH_RELEASE;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = pt_inc;
                end
            end
            PH_RELEASE:
            begin
                if (pt_inc >= {8'd0, cfg.release_ticks})
                begin
                    phase_next       = PH_ACK_LOW;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = pt_inc;
                end
            end
            PH_ACK_LOW, PH_BIT_LOW:
            begin
                if (!item.line_level)
                begin
                    if (work_pt >= cfg.timeout_ticks)
                    begin
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        phase_ticks_next = pt_inc;
                    end
                end
                else
                begin
                    phase_next       = (work_ph == PH_ACK_LOW) ? PH_ACK_HIGH : PH_BIT_HIGH;
                    phase_ticks_next = 16'd1;
                    if (work_ph == PH_BIT_LOW)
                    begin
                        pulse_ticks_next = 16'd1;
                    end
                end
            end
            PH_ACK_HIGH:
            begin
                if (item.line_level)
                begin
                    if (work_pt >= cfg.timeout_ticks)
                    begin
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        phase_ticks_next = pt_inc;
                    end
                end
                else
                begin
                    phase_next       = PH_BIT_LOW;
                    phase_ticks_next = 16'd1;
                end
            end
            PH_BIT_HIGH:
            begin
                if (item.line_level)
                begin
                    if (work_pt >= cfg.timeout_ticks)
                    begin
                        timed_out = 1'b1;
                    end
                    else
                    begin
                        phase_ticks_next = pt_inc;
                        // saturate the pulse width
                        if (work_pu != 16'hFFFF)
                        begin
                            pulse_ticks_next = work_pu + 16'd1;
                        end
                    end
                end
                else
                begin
                    frame_next     = {work_fs[HSR_FRAME_BITS-2:0], bit_val};
                    bit_count_next = bc_inc;
                    if (bc_inc >= FRAME_BITS_6)
                    begin
                        sum8 = frame_next[39:32] + frame_next[23:16];
                        if (sum8 == frame_next[7:0])
                        begin
                            humidity_next    = frame_next[39:32];
                            temperature_next = frame_next[23:16];
                            status_next      = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_CHECKSUM;
                        end
                        phase_next       = PH_IDLE;
                        phase_ticks_next = '0;
                        done             = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_BIT_LOW;
                        phase_ticks_next = 16'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (timed_out)
        begin
            status_next      = ST_TIMEOUT;
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
            done             = 1'b1;
        end

        res.drive_low   = drive;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.status      = status_next;
        res.humidity    = humidity_next;
        res.temperature = temperature_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            pulse_ticks_reg <= '0;
            bit_count_reg   <= '0;
            frame_reg       <= '0;
            humidity_reg    <= '0;
            temperature_reg <= '0;
            status_reg      <= ST_OK;
        end
        else if (item_take)
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            pulse_ticks_reg <= pulse_ticks_next;
            bit_count_reg   <= bit_count_next;
            frame_reg       <= frame_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
            status_reg      <= status_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/humidity_sensor_single_wire_reader_unit.sv -----
// Single-wire humidity sensor reader: top level with queues and registers.
// Usage:
//   Push one sample item per microsecond tick (line_level, start_request)
//   while full is low. Every item yields exactly one result, read from the
//   result side while empty is low and taken with pop.
//   Each result carries drive_low for the open-drain pin, busy_res, a one-tick
//   done_res with status (ok, checksum mismatch, timeout), and the humidity
//   and temperature bytes of the last good frame.
//   The engine step is combinational between the two queues and writes the
//   result queue at the edge that takes the item from the input queue.
//   Throughput: one item per cycle while the result queue has room; both
//   queues are two entries deep.
//   If the result side stops popping, the result queue fills, the engine holds,
//   then the input queue fills and full rises; nothing is dropped.
//   Reset clears both queues, the reader goes idle with status ok and zero
//   readings, and the registers load their defaults (18000, 40, 10000, 40).
//   Register writes (wr_en, wr_index, wr_data) take effect at the next edge and
//   are meant for when the block is idle.
`default_nettype none

module humidity_sensor_single_wire_reader_unit #(
    parameter int QUEUE_DEPTH = hsr_pkg::HSR_QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [hsr_pkg::HSR_REG_IDX_W-1:0]  wr_index,
    input  wire logic [hsr_pkg::HSR_CFG_DATA_W-1:0] wr_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               line_level,
    input  wire logic                               start_request,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    drive_low,
    output logic                                    busy_res,
    output logic                                    done_res,
    output logic [1:0]                              status,
    output logic [7:0]                              humidity,
    output logic [7:0]                              temperature
);

    import hsr_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item;
    item_t   eng_item;
    logic    eng_empty;
    logic    eng_valid;
    logic    eng_take;
    logic    res_full;
    logic    res_push;
    result_t eng_res;
    result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks     <= HSR_START_LOW_RST;
            cfg_reg.release_ticks       <= HSR_RELEASE_RST;
            cfg_reg.timeout_ticks       <= HSR_TIMEOUT_RST;
            cfg_reg.one_threshold_ticks <= HSR_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_START_LOW: cfg_reg.start_low_ticks     <= wr_data;
                REG_RELEASE:   cfg_reg.release_ticks       <= wr_data[7:0];
                REG_TIMEOUT:   cfg_reg.timeout_ticks       <= wr_data;
                REG_THRESHOLD: cfg_reg.one_threshold_ticks <= wr_data[7:0];
            endcase
        end
    end

    assign in_item.line_level    = line_level;
    assign in_item.start_request = start_request;

    hsr_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (eng_take),
        .dout  (eng_item),
        .empty (eng_empty)
    );

    assign eng_valid = !eng_empty;

    hsr_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (eng_item),
        .item_valid (eng_valid),
        .item_take  (eng_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (eng_res)
    );

    hsr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (eng_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign drive_low   = out_res.drive_low;
    assign busy_res    = out_res.busy_res;
    assign done_res    = out_res.done_res;
    assign status      = out_res.status;
    assign humidity    = out_res.humidity;
    assign temperature = out_res.temperature;

    // a finished reading is never still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done and busy set in one result");

    // the line is only pulled low during a reading
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && drive_low) |-> busy_res)
        else $error("drive_low outside a reading");

    // an engine step always lands in the result queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        eng_take |=> !empty)
        else $error("engine result lost");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the single-wire humidity sensor reader: sensor frames, checks per tick.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hsr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } read_phase_t;

    // Tracks the reader state per sampled tick and holds the results still owed.
    class reading_tracker;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [15:0] timeout_ticks;
        logic [7:0]  one_threshold_ticks;

        read_phase_t phase;
        logic [15:0] phase_ticks;
        logic [15:0] pulse_ticks;
        logic [5:0]  bit_count;
        logic [39:0] frame_bits;
        logic [7:0]  humidity_q;
        logic [7:0]  temperature_q;
        status_t     status_q;

        result_t     pending[$];
        int          errors;
        int          worked_ticks;

        function new();
            start_low_ticks     = 16'd18000;
            release_ticks       = 8'd40;
            timeout_ticks       = 16'd10000;
            one_threshold_ticks = 8'd40;
            phase               = PH_IDLE;
            phase_ticks         = '0;
            pulse_ticks         = '0;
            bit_count           = '0;
            frame_bits          = '0;
            humidity_q          = '0;
            temperature_q       = '0;
            status_q            = ST_OK;
            errors              = 0;
            worked_ticks        = 0;
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function void apply_setting(reg_idx_t idx, logic [15:0] value);
            case (idx)
                REG_START_LOW: start_low_ticks     = value;
                REG_RELEASE:   release_ticks       = value[7:0];
                REG_TIMEOUT:   timeout_ticks       = value;
                REG_THRESHOLD: one_threshold_ticks = value[7:0];
                default: ;
            endcase
        endfunction

        // One more sample at the awaited level; 1 means the wait ran out.
        function bit count_wait();
            if (phase_ticks >= timeout_ticks)
                return 1'b1;
            phase_ticks = phase_ticks + 16'd1;
            return 1'b0;
        endfunction

        function void note_sample(bit level, bit req);
            result_t    r;
            bit         timed_out;
            logic [7:0] b0;
            logic [7:0] b2;
            logic [7:0] b4;

            r = '0;
            timed_out = 1'b0;
            if (phase == PH_IDLE && req)
            begin
                phase       = PH_START_LOW;
                phase_ticks = '0;
                pulse_ticks = '0;
                bit_count   = '0;
                frame_bits  = '0;
            end
            if (phase != PH_IDLE)
                worked_ticks++;

            case (phase)
                PH_START_LOW:
                begin
                    r.drive_low = 1'b1;
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= start_low_ticks)
                    begin
                        phase       = PH_RELEASE;
                        phase_ticks = '0;
                    end
                end
                PH_RELEASE:
                begin
                    phase_ticks = phase_ticks + 16'd1;
                    if (phase_ticks >= {8'd0, release_ticks})
                    begin
                        phase       = PH_ACK_LOW;
                        phase_ticks = '0;
                    end
                end
                PH_ACK_LOW:
                    if (!level)
                        timed_out = count_wait();
                    else
                    begin
                        phase       = PH_ACK_HIGH;
                        phase_ticks = 16'd1;
                    end
                PH_ACK_HIGH:
                    if (level)
                        timed_out = count_wait();
                    else
                    begin
                        phase       = PH_BIT_LOW;
                        phase_ticks = 16'd1;
                    end
                PH_BIT_LOW:
                    if (!level)
                        timed_out = count_wait();
                    else
                    begin
                        phase       = PH_BIT_HIGH;
                        phase_ticks = 16'd1;
                        pulse_ticks = 16'd1;
                    end
                PH_BIT_HIGH:
                    if (level)
                    begin
                        timed_out = count_wait();
                        if (!timed_out && pulse_ticks != 16'hFFFF)
                            pulse_ticks = pulse_ticks + 16'd1;
                    end
                    else
                    begin
                        frame_bits = {frame_bits[38:0], pulse_ticks > {8'd0, one_threshold_ticks}};
                        bit_count  = bit_count + 6'd1;
                        if (bit_count >= 6'd40)
                        begin
                            b0 = frame_bits[39:32];
                            b2 = frame_bits[23:16];
                            b4 = frame_bits[7:0];
                            if (8'(b0 + b2) == b4)
                            begin
                                humidity_q    = b0;
                                temperature_q = b2;
                                status_q      = ST_OK;
                            end
                            else
                                status_q = ST_CHECKSUM;
                            phase       = PH_IDLE;
                            phase_ticks = '0;
                            r.done_res  = 1'b1;
                        end
                        else
                        begin
                            phase       = PH_BIT_LOW;
                            phase_ticks = 16'd1;
                        end
                    end
                default: ;
            endcase

            if (timed_out)
            begin
                status_q    = ST_TIMEOUT;
                phase       = PH_IDLE;
                phase_ticks = '0;
                r.done_res  = 1'b1;
            end

            r.busy_res    = (phase != PH_IDLE);
            r.status      = status_q;
            r.humidity    = humidity_q;
            r.temperature = temperature_q;
            pending.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("drive_low", want.drive_low, got.drive_low);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("humidity", want.humidity, got.humidity);
            compare_field("temperature", want.temperature, got.temperature);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       wr_en;
    reg_idx_t   wr_index;
    logic [15:0] wr_data;
    logic       push;
    logic       full;
    logic       line_level;
    logic       start_request;
    logic       empty;
    logic       pop;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity;
    logic [7:0] temperature;

    reading_tracker tracker;
    int             stall_pct = 26;

    humidity_sensor_single_wire_reader_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .push          (push),
        .full          (full),
        .line_level    (line_level),
        .start_request (start_request),
        .empty         (empty),
        .pop           (pop),
        .drive_low     (drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .status        (status),
        .humidity      (humidity),
        .temperature   (temperature)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Result side: stall at random, check every popped result.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            tracker.check_result({drive_low, busy_res, done_res, status, humidity, temperature});
    end

    task automatic send_tick(input bit level, input bit req);
        @(negedge clk);
        while ($urandom_range(0, 99) < stall_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push          <= 1'b1;
        line_level    <= level;
        start_request <= req;
        do
            @(posedge clk);
        while (full);
        tracker.note_sample(level, req);
    endtask

    // Hold the line at one level for n ticks, stopping as soon as the reader goes idle.
    task automatic hold_line(input bit level, input int n);
        for (int i = 0; i < n && tracker.busy(); i++)
            send_tick(level, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_read();
        while (tracker.busy())
            send_tick(1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        tracker.apply_setting(idx, value);
    endtask

    task automatic load_settings(input int start_low, input int release_len,
                                 input int timeout_len, input int threshold);
        settle();
        write_reg(REG_START_LOW, 16'(start_low));
        write_reg(REG_RELEASE, 16'(release_len));
        write_reg(REG_TIMEOUT, 16'(timeout_len));
        write_reg(REG_THRESHOLD, 16'(threshold));
    endtask

    function automatic logic [39:0] make_frame(input bit good);
        logic [7:0] b0;
        logic [7:0] b2;
        b0 = 8'($urandom);
        b2 = 8'($urandom);
        return {b0, 8'($urandom), b2, 8'($urandom), good ? 8'(b0 + b2) : 8'($urandom)};
    endfunction

    // Play the sensor side of one read; with stretch and a timeout of at most 64, one wait outlasts the timeout.
    task automatic run_frame(input logic [39:0] frame, input bit stretch);
        int victim;
        int lim;
        int thr;
        int over;
        int n;

        lim    = (tracker.timeout_ticks < 3) ? int'(tracker.timeout_ticks) : 3;
        thr    = tracker.one_threshold_ticks;
        over   = int'(tracker.timeout_ticks) + 1;
        victim = (stretch && tracker.timeout_ticks <= 64) ? int'($urandom_range(0, 81)) : -1;

        send_tick(1'($urandom_range(0, 1)), 1'b1);
        // line is don't-care while the start pulse and release run
        while (tracker.phase == PH_START_LOW || tracker.phase == PH_RELEASE)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

        hold_line(1'b0, (victim == 0) ? over : int'($urandom_range(0, lim)));
        hold_line(1'b1, (victim == 1) ? over : int'($urandom_range(1, lim)));
        for (int i = 39; i >= 0; i--)
        begin
            n = $urandom_range(1, lim);
            if (victim == 2 + 2 * (39 - i))
                n = over;
            hold_line(1'b0, n);
            n = frame[i] ? thr + 1 + int'($urandom_range(0, 1))
                         : ((thr == 0) ? 1 : int'($urandom_range(1, thr)));
            if (n > tracker.timeout_ticks)
                n = tracker.timeout_ticks;
            if (victim == 3 + 2 * (39 - i))
                n = over;
            hold_line(1'b1, n);
        end
        hold_line(1'b0, 1);
        drain_read();
    endtask

    initial
    begin
        int base;
        int iter;
        int pick;
        int thr;
        int to;

        tracker       = new();
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_START_LOW;
        wr_data       = '0;
        push          = 1'b0;
        line_level    = 1'b0;
        start_request = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values on the first results
        repeat (3) send_tick(1'($urandom_range(0, 1)), 1'b0);

        // shortest phases, one-tick timeout, every pulse a one
        load_settings(0, 0, 1, 0);
        run_frame(make_frame(1'b1), 1'b0);
        run_frame(make_frame(1'b1), 1'b1);

        // checksum sum wraps past 255, then a checksum mismatch, then a read with one wait past the timeout
        load_settings(3, 2, 20, 1);
        run_frame({8'hFF, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b0);
        run_frame({8'h12, 8'h00, 8'h34, 8'h00, 8'h47}, 1'b0);
        run_frame(make_frame(1'b1), 1'b1);

        base = tracker.worked_ticks;
        iter = 0;
        while (tracker.worked_ticks - base < 350)
        begin
            if (iter % 4 == 0)
            begin
                thr = $urandom_range(0, 4);
                to  = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 3))
                                                  : int'($urandom_range(thr + 2, 24));
                load_settings($urandom_range(0, 12), $urandom_range(0, 6), to, thr);
            end
            stall_pct = (tracker.worked_ticks - base >= 120 &&
                         tracker.worked_ticks - base < 240) ? 0 : 26;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_frame(make_frame($urandom_range(0, 4) != 0), $urandom_range(0, 3) == 0);
            else if (pick < 85)
                repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), 1'b0);
            else
            begin
                // broken read: start, then random line noise
                send_tick(1'($urandom_range(0, 1)), 1'b1);
                hold_line(1'($urandom_range(0, 1)), $urandom_range(1, 40));
                repeat ($urandom_range(1, 40))
                    if (tracker.busy())
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                drain_read();
            end
            iter++;
        end
        stall_pct = 26;

        @(negedge clk);
        push <= 1'b0;
        for (int k = 0; k < 2000 && tracker.pending.size() != 0; k++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/hsr_pkg.sv
hw/rtl/hsr_fifo.sv
hw/rtl/hsr_engine.sv
hw/rtl/humidity_sensor_single_wire_reader_unit.sv
sim/testbench.sv
